// ----- hw/rtl/akvt_pkg.sv -----
`timescale 1ns / 1ps
// akvt_pkg: shared constants and types of the aging key/value table
// no dependencies

package akvt_pkg;

    localparam int STAMP_BITS       = 32;
    localparam int TIMEOUT_BITS     = 16;
    localparam int MAX_ENTRIES_BITS = 5;
    localparam int MODE_BITS        = 2;
    localparam int CFG_INDEX_BITS   = 8;
    localparam int CFG_DATA_BITS    = 16;

    typedef logic [MODE_BITS-1:0]      t_mode;
    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;

    localparam t_mode MODE_GET = 2'd0;
    localparam t_mode MODE_SET = 2'd1;
    localparam t_mode MODE_DEL = 2'd2;

    localparam t_cfg_index CFG_TIMEOUT     = 8'd0;
    localparam t_cfg_index CFG_MAX_ENTRIES = 8'd1;

    localparam logic [MAX_ENTRIES_BITS-1:0] MAX_ENTRIES_RESET = 5'd16;

endpackage

// ----- hw/rtl/aging_key_value_table.sv -----
`timescale 1ns / 1ps
// aging_key_value_table: key/value/stamp table held in one entry memory, depends on akvt_pkg
// a result is produced after the scan of slots 0 to lim-1 (lim = slot limit) and the eval, decide and resp states
// input beats are taken only in idle, not during a scan or a pending result; the scan reads one slot per cycle
// a result held by the receiver holds off the next input beat
// reset: synchronous; slot valid bits and entry count clear at once, no clearing pass;
// registers return to timeout 0 and 16 slots

module aging_key_value_table
    import akvt_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]         i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]          i_cfg_data,

    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [MODE_BITS-1:0]              i_mode,
    input  logic [KEY_BITS-1:0]               i_lookup_key,
    input  logic [VALUE_BITS-1:0]             i_new_value,
    input  logic [STAMP_BITS-1:0]             i_now_seconds,

    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_hit,
    output logic [VALUE_BITS-1:0]             o_found_value,
    output logic                              o_status,
    output logic [$clog2(DEPTH+1)-1:0]        o_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > MAX_ENTRIES_BITS) ? CW : MAX_ENTRIES_BITS;
    localparam int EW = KEY_BITS + VALUE_BITS + STAMP_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_EVAL   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    // configuration
    logic [TIMEOUT_BITS-1:0]     r_timeout;
    logic [MAX_ENTRIES_BITS-1:0] r_max_entries;

    // control
    logic [2:0]          r_state;
    logic [AW-1:0]       r_addr;
    logic                r_pend;
    logic [AW-1:0]       r_chk_idx;
    logic [CW-1:0]       r_count;

    // request
    t_mode               r_mode;
    logic [KEY_BITS-1:0] r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [STAMP_BITS-1:0] r_now;

    // scan results
    logic                r_found;
    logic [AW-1:0]       r_match_idx;
    logic [VALUE_BITS-1:0] r_match_val;
    logic                r_free_found;
    logic [AW-1:0]       r_free_idx;

    // pending result
    logic                r_res_hit;
    logic [VALUE_BITS-1:0] r_res_val;
    logic                r_res_status;

    // output register
    logic                r_o_valid;
    logic                r_o_hit;
    logic [VALUE_BITS-1:0] r_o_val;
    logic                r_o_status;
    logic [CW-1:0]       r_o_count;

    // entry memory and valid bits
    logic [EW-1:0]       r_mem [DEPTH];
    logic [EW-1:0]       r_rd_data;
    logic                r_rd_vld;
    logic [DEPTH-1:0]    r_valid;

    logic                w_in_beat;
    logic [MW-1:0]       w_max_ext;
    logic [CW-1:0]       w_lim;
    logic                w_last;

    logic [STAMP_BITS-1:0] w_rd_stamp;
    logic [VALUE_BITS-1:0] w_rd_val;
    logic [KEY_BITS-1:0]   w_rd_key;
    logic [STAMP_BITS:0]   w_expiry;
    logic                  w_live;
    logic                  w_match;

    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic [EW-1:0]       w_wr_data;
    logic                n_res_hit;
    logic [VALUE_BITS-1:0] n_res_val;
    logic                n_res_status;
    logic [CW-1:0]       n_count;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign w_in_beat   = i_valid && o_ready;

    assign o_valid       = r_o_valid;
    assign o_hit         = r_o_hit;
    assign o_found_value = r_o_val;
    assign o_status      = r_o_status;
    assign o_entry_count = r_o_count;

    // slot limit
    assign w_max_ext = MW'(r_max_entries);
    assign w_lim = (r_max_entries == '0 || w_max_ext > MW'(DEPTH)) ? CW'(DEPTH)
                                                                   : CW'(r_max_entries);
    assign w_last = (CW'(r_addr) + CW'(1)) == w_lim;

    // liveness of the slot just read
    assign w_rd_stamp = r_rd_data[STAMP_BITS-1:0];
    assign w_rd_val   = r_rd_data[STAMP_BITS +: VALUE_BITS];
    assign w_rd_key   = r_rd_data[STAMP_BITS+VALUE_BITS +: KEY_BITS];
    assign w_expiry   = {1'b0, w_rd_stamp} + (STAMP_BITS+1)'(r_timeout);
    assign w_live     = r_rd_vld && (w_rd_stamp != '0) &&
                        ((r_timeout == '0) || (w_expiry >= {1'b0, r_now}));
    assign w_match    = w_live && (w_rd_key == r_key);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= '0;
            r_max_entries <= MAX_ENTRIES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TIMEOUT:     r_timeout     <= i_cfg_data[TIMEOUT_BITS-1:0];
                CFG_MAX_ENTRIES: r_max_entries <= i_cfg_data[MAX_ENTRIES_BITS-1:0];
                default: ;
            endcase
        end
    end

    // decision on the finished scan
    always_comb begin
        w_wr_en      = 1'b0;
        w_wr_addr    = r_match_idx;
        w_wr_data    = {r_key, r_value, r_now};
        n_res_hit    = 1'b0;
        n_res_val    = '0;
        n_res_status = 1'b0;
        n_count      = r_count;
        case (r_mode)
            MODE_GET: begin
                n_res_hit = r_found;
                n_res_val = r_found ? r_match_val : '0;
            end
            MODE_SET: begin
                n_res_hit = r_found;
                if (r_found) begin
                    w_wr_en = 1'b1;
                end else if (r_count < w_lim && r_free_found) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_free_idx;
                    n_count   = r_count + CW'(1);
                end else begin
                    n_res_status = 1'b1;
                end
            end
            MODE_DEL: begin
                n_res_hit = r_found;
                if (r_found) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = {r_key, r_match_val, {STAMP_BITS{1'b0}}};
                    if (r_count != '0) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: ;
        endcase
        if (r_state != S_DECIDE) begin
            w_wr_en = 1'b0;
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[r_addr];
            if (w_wr_en) begin
                r_valid[w_wr_addr] <= 1'b1;
            end
        end
    end

    // request latch and scan bookkeeping
    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_addr;
        if (w_in_beat) begin
            r_mode  <= i_mode;
            r_key   <= i_lookup_key;
            r_value <= i_new_value;
            r_now   <= i_now_seconds;
        end
        if (w_in_beat) begin
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_pend) begin
            if (w_match && !r_found) begin
                r_found     <= 1'b1;
                r_match_idx <= r_chk_idx;
                r_match_val <= w_rd_val;
            end
            if (!w_live && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_chk_idx;
            end
        end
        if (r_state == S_DECIDE) begin
            r_res_hit    <= n_res_hit;
            r_res_val    <= n_res_val;
            r_res_status <= n_res_status;
        end
        if (r_state == S_RESP && (!r_o_valid || i_ready)) begin
            r_o_hit    <= r_res_hit;
            r_o_val    <= r_res_val;
            r_o_status <= r_res_status;
            r_o_count  <= r_count;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_addr    <= '0;
            r_pend    <= 1'b0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_pend <= (r_state == S_SCAN);
            if (r_state == S_RESP && (!r_o_valid || i_ready)) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_beat) begin
                        r_addr  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_last) begin
                        r_state <= S_EVAL;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_EVAL: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_count <= n_count;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_o_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above table depth");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> ($past(r_state) == S_DECIDE))
        else $error("entry count changed outside decision step");

    a_value_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_val != '0)) |-> r_o_hit)
        else $error("nonzero value without hit");

    a_status_on_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && n_res_status) |-> (r_mode == MODE_SET && !r_found))
        else $error("full status outside a failed insert");

    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend)
        else $error("scan read pending while idle");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for aging_key_value_table, a cycle-free shadow table predicts each reply
// depends on akvt_pkg and the table rtl

module tb;
    import akvt_pkg::*;

    localparam int     SLOTS          = 16;
    localparam int     POOL_KEYS      = 20;
    localparam int     HOLDOFF_CYCLES = 400;
    localparam int     SETTLE_CYCLES  = 40;
    localparam t_mode  MODE_UNUSED    = 2'd3;

    typedef struct packed {
        logic        hit;
        logic [47:0] found_value;
        logic        status;
        logic [4:0]  entry_count;
    } t_reply;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} t_ready_style;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = CFG_TIMEOUT;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [MODE_BITS-1:0]      i_mode = MODE_GET;
    logic [31:0]               i_lookup_key = '0;
    logic [47:0]               i_new_value = '0;
    logic [STAMP_BITS-1:0]     i_now_seconds = 32'd1;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic                      o_hit;
    logic [47:0]               o_found_value;
    logic                      o_status;
    logic [4:0]                o_entry_count;

    aging_key_value_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_lookup_key  (i_lookup_key),
        .i_new_value   (i_new_value),
        .i_now_seconds (i_now_seconds),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_hit         (o_hit),
        .o_found_value (o_found_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always #10 i_clk = ~i_clk;

    // shadow of the slot table
    logic [31:0]  tbl_keys   [SLOTS];
    logic [47:0]  tbl_values [SLOTS];
    logic [31:0]  tbl_stamps [SLOTS];
    int unsigned  tbl_count;
    int unsigned  peak_count;
    logic [15:0]  tbl_timeout;
    logic [4:0]   tbl_max_entries;

    t_reply       replies_due[$];
    logic [31:0]  key_pool [POOL_KEYS];

    int           burst_left;
    int           requests_sent;
    int           settings_used;
    int           replies_seen;
    int           hits_seen;
    int           refused_inserts;
    int           mismatches;

    int           holdoff_requests;
    int           holdoff_taken;
    int           holdoff_left;
    t_ready_style ready_style;
    int           ready_style_left;

    function automatic int slot_limit();
        if (tbl_max_entries == 5'd0 || tbl_max_entries > SLOTS)
            return SLOTS;
        return tbl_max_entries;
    endfunction

    function automatic bit slot_is_live(int slot, logic [31:0] now);
        logic [32:0] expiry;
        expiry = {1'b0, tbl_stamps[slot]} + {17'd0, tbl_timeout};
        if (tbl_stamps[slot] == '0)
            return 1'b0;
        if (tbl_timeout == '0)
            return 1'b1;
        return expiry >= {1'b0, now};
    endfunction

    function automatic t_reply access_table(t_mode mode, logic [31:0] key,
                                            logic [47:0] value, logic [31:0] now);
        t_reply r;
        int     lim;
        int     match;
        bit     placed;
        r = '0;
        lim = slot_limit();
        match = -1;
        placed = 1'b0;
        if (mode != MODE_UNUSED) begin
            for (int i = 0; i < lim; i++)
                if (match < 0 && slot_is_live(i, now) && tbl_keys[i] == key)
                    match = i;
            r.hit = (match >= 0);
        end
        case (mode)
            MODE_GET: begin
                if (match >= 0)
                    r.found_value = tbl_values[match];
            end
            MODE_SET: begin
                if (match >= 0) begin
                    tbl_values[match] = value;
                    tbl_stamps[match] = now;
                end else begin
                    if (tbl_count < lim) begin
                        for (int i = 0; i < lim; i++) begin
                            if (!placed && !slot_is_live(i, now)) begin
                                tbl_keys[i] = key;
                                tbl_values[i] = value;
                                tbl_stamps[i] = now;
                                tbl_count++;
                                placed = 1'b1;
                            end
                        end
                    end
                    r.status = !placed;
                end
            end
            MODE_DEL: begin
                if (match >= 0) begin
                    tbl_stamps[match] = '0;
                    if (tbl_count > 0)
                        tbl_count--;
                end
            end
            default: ;
        endcase
        if (tbl_count > peak_count)
            peak_count = tbl_count;
        r.entry_count = tbl_count[4:0];
        return r;
    endfunction

    task automatic send_request(input t_mode mode, input logic [31:0] key,
                                input logic [47:0] value, input logic [31:0] now);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_lookup_key  <= key;
        i_new_value   <= value;
        i_now_seconds <= now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        replies_due.push_back(access_table(mode, key, value, now));
        requests_sent++;
    endtask

    task automatic drain_replies();
        i_valid <= 1'b0;
        burst_left = 0;
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_table_config(input logic [15:0] timeout,
                                      input logic [15:0] max_entries);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_TIMEOUT;
        i_cfg_data  <= timeout;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tbl_timeout = timeout;
        i_cfg_index <= CFG_MAX_ENTRIES;
        i_cfg_data  <= max_entries;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tbl_max_entries = max_entries[4:0];
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // mostly pool keys with a slowly moving clock, plus jumps both ways
    task automatic run_random_phase(input logic [15:0] timeout, input logic [15:0] max_entries,
                                    input int pool_size, input int beats,
                                    input logic [31:0] start_time);
        logic [31:0] now;
        logic [31:0] key;
        logic [63:0] wide;
        t_mode       mode;
        int          roll;
        int          span;
        write_table_config(timeout, max_entries);
        now = start_time;
        span = int'(timeout) + 3;
        for (int n = 0; n < beats; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                mode = MODE_SET;
            else if (roll < 72)
                mode = MODE_GET;
            else if (roll < 97)
                mode = MODE_DEL;
            else
                mode = MODE_UNUSED;
            key = key_pool[$urandom_range(0, pool_size - 1)];
            if (mode != MODE_SET && $urandom_range(0, 9) == 0)
                key = $urandom;
            wide = {$urandom, $urandom};
            roll = $urandom_range(0, 29);
            if (roll == 0)
                now = now - $urandom_range(1, 2 * span);
            else if (roll == 1)
                now = now + $urandom_range(span, 3 * span);
            else
                now = now + $urandom_range(0, 1);
            if (mode != MODE_SET && $urandom_range(0, 99) == 0)
                send_request(mode, key, wide[47:0], 32'd0);
            else
                send_request(mode, key, wide[47:0], now);
        end
        drain_replies();
    endtask

    task automatic test_basic_access();
        send_request(MODE_GET, 32'h0000_0000, 48'h0, 32'd1);
        send_request(MODE_SET, 32'h0000_0000, 48'h0, 32'd1);
        send_request(MODE_SET, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_GET, 32'hFFFF_FFFF, 48'h0, 32'hFFFF_FFFF);
        send_request(MODE_SET, 32'h0000_0000, 48'h0123_4567_89AB, 32'd2);
        send_request(MODE_GET, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 32'd3);
        send_request(MODE_DEL, 32'h0000_0000, 48'h0, 32'd3);
        send_request(MODE_GET, 32'h0000_0000, 48'h0, 32'd4);
        send_request(MODE_DEL, 32'h0000_0000, 48'h0, 32'd4);
        send_request(MODE_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd5);
        // stamp of zero: counted, never live
        send_request(MODE_SET, 32'h5A5A_5A5A, 48'hA5A5_A5A5_A5A5, 32'd0);
        send_request(MODE_GET, 32'h5A5A_5A5A, 48'h0, 32'd7);
        send_request(MODE_DEL, 32'hFFFF_FFFF, 48'h0, 32'd8);
        drain_replies();
    endtask

    task automatic test_entry_expiry();
        write_table_config(16'd5, 16'd16);
        send_request(MODE_SET, 32'h0000_00A5, 48'h0000_1111_2222, 32'd100);
        send_request(MODE_GET, 32'h0000_00A5, 48'h0, 32'd105);
        send_request(MODE_GET, 32'h0000_00A5, 48'h0, 32'd106);
        send_request(MODE_GET, 32'h0000_00A5, 48'h0, 32'd40);
        drain_replies();
        // stamp plus lifetime runs past 32 bits
        write_table_config(16'hFFFF, 16'd16);
        send_request(MODE_SET, 32'h0000_C3C3, 48'h8000_0000_0001, 32'hFFFF_FFF0);
        send_request(MODE_GET, 32'h0000_C3C3, 48'h0, 32'hFFFF_FFFF);
        send_request(MODE_GET, 32'h0000_C3C3, 48'h0, 32'h0000_FFEF);
        drain_replies();
    endtask

    task automatic test_slot_limit();
        write_table_config(16'd0, 16'd1);
        send_request(MODE_SET, 32'h0000_0077, 48'h7777_7777_7777, 32'd200);
        send_request(MODE_SET, 32'h0000_00A5, 48'h0000_3333_4444, 32'd200);
        send_request(MODE_GET, 32'h0000_00A5, 48'h0, 32'd201);
        send_request(MODE_DEL, 32'h0000_00A5, 48'h0, 32'd202);
        send_request(MODE_SET, 32'h0000_0077, 48'h7777_7777_7777, 32'd203);
        drain_replies();
    endtask

    task automatic test_output_backpressure();
        logic [63:0] wide;
        write_table_config(16'd0, 16'd16);
        holdoff_requests <= holdoff_requests + 1;
        for (int n = 0; n < 24; n++) begin
            wide = {$urandom, $urandom};
            send_request(($urandom_range(0, 1) == 0) ? MODE_SET : MODE_GET,
                         key_pool[$urandom_range(0, POOL_KEYS - 1)], wide[47:0],
                         32'd1000 + n);
        end
        drain_replies();
    endtask

    task automatic test_random_traffic();
        run_random_phase(16'd0,     16'd16, POOL_KEYS, 90, $urandom);
        run_random_phase(16'd0,     16'd3,  5,         80, $urandom);
        run_random_phase(16'hFFFF,  16'd16, 12,        90, 32'hFFFF_FF00);
        run_random_phase(16'd20,    16'd16, POOL_KEYS, 90, $urandom);
        run_random_phase(16'd4,     16'd5,  8,         80, $urandom);
        run_random_phase(16'd0,     16'd31, POOL_KEYS, 90, $urandom);
        run_random_phase(16'd9,     16'd0,  12,        80, $urandom);
        run_random_phase(16'd1,     16'd1,  3,         60, $urandom);
    endtask

    task automatic check_reply();
        t_reply want;
        if (replies_due.size() == 0) begin
            $error("result beat with no request outstanding");
            mismatches++;
            return;
        end
        want = replies_due.pop_front();
        replies_seen++;
        if (o_hit)
            hits_seen++;
        if (o_status)
            refused_inserts++;
        if (o_hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, o_hit);
            mismatches++;
        end
        if (o_found_value !== want.found_value) begin
            $error("found_value: expected %h, got %h", want.found_value, o_found_value);
            mismatches++;
        end
        if (o_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, o_status);
            mismatches++;
        end
        if (o_entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, o_entry_count);
            mismatches++;
        end
    endtask

    // result check and receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            check_reply();
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_ready <= 1'b0;
        end else if (holdoff_taken != holdoff_requests) begin
            holdoff_taken = holdoff_requests;
            holdoff_left = HOLDOFF_CYCLES - 1;
            i_ready <= 1'b0;
        end else begin
            if (ready_style_left == 0) begin
                ready_style = t_ready_style'($urandom_range(0, 2));
                ready_style_left = $urandom_range(8, 80);
            end
            ready_style_left--;
            case (ready_style)
                READY_ALWAYS: i_ready <= 1'b1;
                READY_COIN:   i_ready <= 1'($urandom_range(0, 1));
                default:      i_ready <= (ready_style_left % 4 == 0);
            endcase
        end
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_keys[i] = '0;
            tbl_values[i] = '0;
            tbl_stamps[i] = '0;
        end
        for (int i = 0; i < POOL_KEYS; i++)
            key_pool[i] = $urandom;
        tbl_count = 0;
        peak_count = 0;
        tbl_timeout = '0;
        tbl_max_entries = MAX_ENTRIES_RESET;
        burst_left = 0;
        requests_sent = 0;
        settings_used = 1;
        replies_seen = 0;
        hits_seen = 0;
        refused_inserts = 0;
        mismatches = 0;
        holdoff_requests = 0;
        holdoff_taken = 0;
        holdoff_left = 0;
        ready_style = READY_ALWAYS;
        ready_style_left = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_access();
        test_entry_expiry();
        test_slot_limit();
        test_output_backpressure();
        test_random_traffic();

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d requests over %0d table settings, %0d replies checked",
                 requests_sent, settings_used, replies_seen);
        $display("%0d hits, %0d refused inserts, peak entry count %0d, %0d mismatches",
                 hits_seen, refused_inserts, peak_count, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
